// ----- rtl/adar_pkg.sv -----
// Shared types, constants and helpers for the AD/AR envelope generator.
package adar_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LEVEL_W   = FRAC_BITS + 1;
  localparam int MUL_W     = FRAC_BITS;
  localparam int PROD_W    = LEVEL_W + MUL_W;
  localparam int CODE_W    = 3;
  localparam int OP_W      = 2;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int OUT_TDATA_W = 24;

  // 1.0 in Q1.16.
  localparam logic [LEVEL_W-1:0] ONE_LEVEL = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [LEVEL_W-1:0] ATTACK_STEP_RST = LEVEL_W'(655);
  localparam logic [MUL_W-1:0]   DECAY_MUL_RST   = MUL_W'(65000);
  localparam logic [LEVEL_W-1:0] FLOOR_LEVEL_RST = LEVEL_W'(66);
  localparam logic               ENV_MODE_RST    = 1'b0;

  // Stage numbers as seen on the result channel.
  localparam logic [CODE_W-1:0] CODE_IDLE    = 3'd0;
  localparam logic [CODE_W-1:0] CODE_ATTACK  = 3'd1;
  localparam logic [CODE_W-1:0] CODE_DECAY   = 3'd2;
  localparam logic [CODE_W-1:0] CODE_SUSTAIN = 3'd3;
  localparam logic [CODE_W-1:0] CODE_RELEASE = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_ATTACK  = 5'b00010,
    ST_DECAY   = 5'b00100,
    ST_SUSTAIN = 5'b01000,
    ST_RELEASE = 5'b10000
  } stage_t;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 2'd0,
    OP_TRIGGER   = 2'd1,
    OP_NOTE_OFF  = 2'd2,
    OP_FORCE_REL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_ATTACK_STEP = 2'd0,
    REG_DECAY_MUL   = 2'd1,
    REG_FLOOR_LEVEL = 2'd2,
    REG_ENV_MODE    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] attack_step;
    logic [MUL_W-1:0]   decay_mul;
    logic [LEVEL_W-1:0] floor_level;
    logic               env_mode;
    logic               decay_load;
  } cfg_t;

  function automatic logic [CODE_W-1:0] stage_code(input stage_t s);
    logic [CODE_W-1:0] c;
    unique case (s)
      ST_IDLE:    c = CODE_IDLE;
      ST_ATTACK:  c = CODE_ATTACK;
      ST_DECAY:   c = CODE_DECAY;
      ST_SUSTAIN: c = CODE_SUSTAIN;
      ST_RELEASE: c = CODE_RELEASE;
      default:    c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/ad_ar_envelope_generator.sv -----
// Top level of the AD/AR envelope generator: channel registers and assertions.
//
// Events arrive on the slave stream: s_tuser carries the event kind (tick,
// trigger, note-off, forced release) and s_tdata the release factor used by a
// forced release. Only a tick produces a beat on the master stream, carrying
// the new level (Q1.16) and the stage number. Settings are written through the
// APB port; a write of the decay factor also reloads the release factor.
//
// An accepted event sits in an input register, where the state update and
// the result are computed in one pass through the level multiplier or the
// attack adder. A tick's result then goes to the result register, which
// drives m_tdata. One event per cycle is sustained unless a tick is stalled.
//
// While the receiver stalls, the result register holds its beat; further
// non-tick events still flow through, and a tick waits in the input register,
// so s_tready drops only when a waiting tick cannot reach the result register.
// Reset clears both channel registers and returns the envelope to idle at
// level zero with all settings at their defaults.
module ad_ar_envelope_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] release_mul
  input  logic [1:0]  s_tuser,   // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [16:0] level, [19:17] stage_out, [23:20] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import adar_pkg::*;

  cfg_t               cfg;
  logic               in_valid;
  op_t                in_op;
  logic [MUL_W-1:0]   in_rel;
  logic               out_free;
  logic               advance;
  logic               emit;
  logic [LEVEL_W-1:0] tick_level;
  logic [CODE_W-1:0]  tick_stage;
  logic [LEVEL_W-1:0] out_level;
  logic [CODE_W-1:0]  out_stage;

  adar_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && ((in_op != OP_TICK) || out_free);
  assign emit     = advance && (in_op == OP_TICK);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op  <= op_t'(s_tuser);
      in_rel <= s_tdata[MUL_W-1:0];
    end
  end

  adar_env_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .step        (advance),
    .op          (in_op),
    .release_mul (in_rel),
    .tick_level  (tick_level),
    .tick_stage  (tick_stage)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_level <= tick_level;
      out_stage <= tick_stage;
    end
  end

  assign m_tdata = {4'b0000, out_stage, out_level};

  a_tick_emits: assert property (@(posedge clk) disable iff (rst)
    emit |=> m_tvalid)
    else $error("accepted tick did not produce a result beat");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_level <= ONE_LEVEL))
    else $error("level above 1.0");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_stage == CODE_IDLE) |-> (out_level == '0))
    else $error("idle stage with nonzero level");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && in_op == OP_TICK && m_tvalid && !m_tready))
    else $error("input stalled without a blocked tick");

endmodule

// ----- rtl/adar_cfg_regs.sv -----
// APB register file for the envelope settings.
module adar_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [adar_pkg::PADDR_W-1:0] paddr,
  input  logic [adar_pkg::PDATA_W-1:0] pwdata,
  output logic [adar_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output adar_pkg::cfg_t               cfg
);
  import adar_pkg::*;

  logic [LEVEL_W-1:0] attack_step;
  logic [MUL_W-1:0]   decay_mul;
  logic [LEVEL_W-1:0] floor_level;
  logic               env_mode;
  logic               decay_load;
  logic               wr_en;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_step <= ATTACK_STEP_RST;
      decay_mul   <= DECAY_MUL_RST;
      floor_level <= FLOOR_LEVEL_RST;
      env_mode    <= ENV_MODE_RST;
      decay_load  <= 1'b0;
    end else begin
      decay_load <= 1'b0;
      if (wr_en) begin
        unique case (idx)
          REG_ATTACK_STEP: attack_step <= pwdata[LEVEL_W-1:0];
          REG_DECAY_MUL: begin
            decay_mul  <= pwdata[MUL_W-1:0];
            decay_load <= 1'b1;
          end
          REG_FLOOR_LEVEL: floor_level <= pwdata[LEVEL_W-1:0];
          REG_ENV_MODE:    env_mode    <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_ATTACK_STEP: prdata = PDATA_W'(attack_step);
      REG_DECAY_MUL:   prdata = PDATA_W'(decay_mul);
      REG_FLOOR_LEVEL: prdata = PDATA_W'(floor_level);
      REG_ENV_MODE:    prdata = PDATA_W'(env_mode);
      default:         prdata = '0;
    endcase
  end

  // The release factor is loaded from the decay value by the registered decay_load strobe after a write.
  assign cfg.attack_step = attack_step;
  assign cfg.decay_mul   = decay_mul;
  assign cfg.floor_level = floor_level;
  assign cfg.env_mode    = env_mode;
  assign cfg.decay_load  = decay_load;

endmodule

// ----- rtl/adar_env_core.sv -----
// Envelope state registers and the combinational update for one event.
module adar_env_core (
  input  logic                        clk,
  input  logic                        rst,
  input  adar_pkg::cfg_t              cfg,
  input  logic                        step,
  input  adar_pkg::op_t               op,
  input  logic [adar_pkg::MUL_W-1:0]  release_mul,
  output logic [adar_pkg::LEVEL_W-1:0] tick_level,
  output logic [adar_pkg::CODE_W-1:0] tick_stage
);
  import adar_pkg::*;

  stage_t             stage;
  stage_t             stage_next;
  stage_t             tick_stage_nx;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] level_next;
  logic [LEVEL_W-1:0] tick_level_nx;
  logic [MUL_W-1:0]   release_factor;
  logic [MUL_W-1:0]   release_factor_next;
  logic [MUL_W-1:0]   mul_sel;
  logic [PROD_W-1:0]  product;
  logic [LEVEL_W-1:0] shrunk;
  logic [LEVEL_W:0]   attack_sum;

  // One shared multiplier serves decay and release.
  always_comb begin
    mul_sel    = (stage == ST_RELEASE) ? release_factor : cfg.decay_mul;
    product    = PROD_W'(level) * PROD_W'(mul_sel);
    shrunk     = product[FRAC_BITS +: LEVEL_W];
    attack_sum = {1'b0, level} + {1'b0, cfg.attack_step};
  end

  always_comb begin
    tick_stage_nx = stage;
    tick_level_nx = level;
    unique case (stage)
      ST_ATTACK: begin
        if (attack_sum >= {1'b0, ONE_LEVEL}) begin
          tick_level_nx = ONE_LEVEL;
          tick_stage_nx = cfg.env_mode ? ST_SUSTAIN : ST_DECAY;
        end else begin
          tick_level_nx = attack_sum[LEVEL_W-1:0];
        end
      end
      ST_DECAY, ST_RELEASE: begin
        if (shrunk <= cfg.floor_level) begin
          tick_level_nx = '0;
          tick_stage_nx = ST_IDLE;
        end else begin
          tick_level_nx = shrunk;
        end
      end
      ST_SUSTAIN: tick_level_nx = ONE_LEVEL;
      default: begin
        tick_level_nx = '0;
        tick_stage_nx = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    stage_next          = stage;
    level_next          = level;
    release_factor_next = release_factor;
    case (op)
      OP_TICK: begin
        stage_next = tick_stage_nx;
        level_next = tick_level_nx;
      end
      OP_TRIGGER: stage_next = ST_ATTACK;
      OP_NOTE_OFF: begin
        if (cfg.env_mode && stage != ST_IDLE) stage_next = ST_RELEASE;
      end
      default: begin
        if (stage != ST_IDLE) begin
          stage_next          = ST_RELEASE;
          release_factor_next = release_mul;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage          <= ST_IDLE;
      level          <= '0;
      release_factor <= DECAY_MUL_RST;
    end else begin
      if (cfg.decay_load) begin
        release_factor <= cfg.decay_mul;
      end else if (step) begin
        release_factor <= release_factor_next;
      end
      if (step) begin
        stage <= stage_next;
        level <= level_next;
      end
    end
  end

  assign tick_level = tick_level_nx;
  assign tick_stage = stage_code(tick_stage_nx);

endmodule
